@@ src/arsl_pkg.sv @@
// Shared types and constants for the address range symbol lookup block.
`default_nettype none

package arsl_pkg;

  localparam int unsigned TableDepth = 1024;
  localparam int unsigned IdxW       = $clog2(TableDepth);
  localparam int unsigned CntW       = $clog2(TableDepth + 1);

  typedef enum logic [1:0] {
    ReqInsert = 2'd0,
    ReqLookup = 2'd1,
    ReqClear  = 2'd2
  } req_e;

  typedef enum logic [2:0] {
    StInserted = 3'd0,
    StZero     = 3'd1,
    StFull     = 3'd2,
    StHit      = 3'd3,
    StMiss     = 3'd4,
    StCleared  = 3'd5
  } status_e;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [31:0] address;
    logic [31:0] range_size;
    logic [23:0] name_offset;
    logic [7:0]  section_index;
    logic [11:0] object_index;
  } req_t;

  typedef struct packed {
    status_e     status;
    logic [23:0] found_name_offset;
    logic [7:0]  found_section;
    logic [11:0] found_object;
  } rsp_t;

  typedef struct packed {
    logic [31:0] start;
    logic [31:0] size;
    logic [23:0] name_offset;
    logic [7:0]  section;
    logic [11:0] object;
  } entry_t;

endpackage

`default_nettype wire

@@ src/address_range_symbol_lookup.sv @@
// Top level of the sorted address range table with binary search lookup.
`default_nettype none

// A word is taken when start is high and busy is low; its result appears on rsp_o
// for exactly one cycle with done_o high, and the receiver cannot stall it. The
// table sits in one synchronous memory with a registered read, and every step
// of a search or a move costs memory reads. Clear, zero size, full and unused
// request codes answer in the cycle after acceptance. A lookup over n entries makes
// up to ceil(log2(n+1)) probes and answers on the first hit it finds. An insert
// runs the search to its end without stopping on a hit, then moves each entry
// above the insert point up by one, one entry per cycle, and then writes the
// new entry and answers.
module address_range_symbol_lookup (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start,
  output logic               busy,
  input  wire arsl_pkg::req_t req_i,
  output logic               done_o,
  output arsl_pkg::rsp_t     rsp_o
);

  typedef enum logic [2:0] {
    Idle,
    Search,
    Check,
    Shift,
    Drain,
    Place
  } state_e;

  state_e                        state_q, state_d;
  logic [arsl_pkg::CntW-1:0]     lo_q, lo_d, hi_q, hi_d, count_q, count_d;
  logic [arsl_pkg::IdxW-1:0]     mid_q, mid_d, rd_q, rd_d, wr_idx_q, wr_idx_d;
  logic                          pend_q, pend_d, done_q, done_d;
  arsl_pkg::req_t                req_q, req_d;
  arsl_pkg::rsp_t                rsp_q, rsp_d;
  arsl_pkg::entry_t              rdata_q;

  arsl_pkg::entry_t              mem_q [arsl_pkg::TableDepth];
  logic                          mem_we;
  logic [arsl_pkg::IdxW-1:0]     mem_wa, rd_addr;
  arsl_pkg::entry_t              mem_wd;

  logic [arsl_pkg::CntW:0]       mid_sum;
  logic [arsl_pkg::IdxW-1:0]     mid;
  logic [31:0]                   diff;
  logic                          hit, go_right, is_lookup;

  assign mid_sum   = {1'b0, lo_q} + {1'b0, hi_q} - {{arsl_pkg::CntW{1'b0}}, 1'b1};
  assign mid       = mid_sum[arsl_pkg::IdxW:1];
  assign diff      = req_q.address - rdata_q.start;
  assign hit       = diff < rdata_q.size;
  assign is_lookup = req_q.req_type == arsl_pkg::ReqLookup;
  assign go_right  = is_lookup ? (rdata_q.start < req_q.address)
                               : (rdata_q.start <= req_q.address);

  always_comb begin
    state_d  = state_q;
    lo_d     = lo_q;
    hi_d     = hi_q;
    count_d  = count_q;
    mid_d    = mid_q;
    rd_d     = rd_q;
    wr_idx_d = wr_idx_q;
    pend_d   = pend_q;
    req_d    = req_q;
    rsp_d    = rsp_q;
    done_d   = 1'b0;
    mem_we   = 1'b0;
    mem_wa   = wr_idx_q;
    mem_wd   = rdata_q;
    rd_addr  = mid;
    case (state_q)
      Idle: begin
        if (start) begin
          req_d = req_i;
          rsp_d = '0;
          lo_d  = '0;
          hi_d  = count_q;
          case (req_i.req_type)
            arsl_pkg::ReqInsert: begin
              if (req_i.range_size == 32'd0) begin
                done_d       = 1'b1;
                rsp_d.status = arsl_pkg::StZero;
              end else if (count_q == arsl_pkg::CntW'(arsl_pkg::TableDepth)) begin
                done_d       = 1'b1;
                rsp_d.status = arsl_pkg::StFull;
              end else begin
                state_d = Search;
              end
            end
            arsl_pkg::ReqLookup: begin
              state_d = Search;
            end
            arsl_pkg::ReqClear: begin
              count_d      = '0;
              done_d       = 1'b1;
              rsp_d.status = arsl_pkg::StCleared;
            end
            default: begin
              done_d       = 1'b1;
              rsp_d.status = arsl_pkg::StMiss;
            end
          endcase
        end
      end
      Search: begin
        if (lo_q == hi_q) begin
          pend_d = 1'b0;
          if (is_lookup) begin
            done_d       = 1'b1;
            rsp_d.status = arsl_pkg::StMiss;
            state_d      = Idle;
          end else if (lo_q == count_q) begin
            state_d = Place;
          end else begin
            rd_d    = arsl_pkg::IdxW'(count_q - {{(arsl_pkg::CntW-1){1'b0}}, 1'b1});
            state_d = Shift;
          end
        end else begin
          mid_d   = mid;
          state_d = Check;
        end
      end
      Check: begin
        if (is_lookup && hit) begin
          done_d                  = 1'b1;
          rsp_d.status            = arsl_pkg::StHit;
          rsp_d.found_name_offset = rdata_q.name_offset;
          rsp_d.found_section     = rdata_q.section;
          rsp_d.found_object      = rdata_q.object;
          state_d                 = Idle;
        end else begin
          if (go_right) begin
            lo_d = arsl_pkg::CntW'(mid_q) + {{(arsl_pkg::CntW-1){1'b0}}, 1'b1};
          end else begin
            hi_d = arsl_pkg::CntW'(mid_q);
          end
          state_d = Search;
        end
      end
      Shift: begin
        rd_addr  = rd_q;
        mem_we   = pend_q;
        pend_d   = 1'b1;
        wr_idx_d = rd_q + {{(arsl_pkg::IdxW-1){1'b0}}, 1'b1};
        if (rd_q == lo_q[arsl_pkg::IdxW-1:0]) begin
          state_d = Drain;
        end else begin
          rd_d = rd_q - {{(arsl_pkg::IdxW-1){1'b0}}, 1'b1};
        end
      end
      Drain: begin
        mem_we  = 1'b1;
        pend_d  = 1'b0;
        state_d = Place;
      end
      Place: begin
        mem_we             = 1'b1;
        mem_wa             = lo_q[arsl_pkg::IdxW-1:0];
        mem_wd.start       = req_q.address;
        mem_wd.size        = req_q.range_size;
        mem_wd.name_offset = req_q.name_offset;
        mem_wd.section     = req_q.section_index;
        mem_wd.object      = req_q.object_index;
        count_d            = count_q + {{(arsl_pkg::CntW-1){1'b0}}, 1'b1};
        done_d             = 1'b1;
        rsp_d.status       = arsl_pkg::StInserted;
        state_d            = Idle;
      end
      default: begin
        state_d = Idle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= Idle;
      lo_q     <= '0;
      hi_q     <= '0;
      count_q  <= '0;
      mid_q    <= '0;
      rd_q     <= '0;
      wr_idx_q <= '0;
      pend_q   <= 1'b0;
      done_q   <= 1'b0;
      rsp_q    <= '0;
    end else begin
      state_q  <= state_d;
      lo_q     <= lo_d;
      hi_q     <= hi_d;
      count_q  <= count_d;
      mid_q    <= mid_d;
      rd_q     <= rd_d;
      wr_idx_q <= wr_idx_d;
      pend_q   <= pend_d;
      done_q   <= done_d;
      rsp_q    <= rsp_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q <= req_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_wa] <= mem_wd;
    end
    rdata_q <= mem_q[rd_addr];
  end

  assign busy   = state_q != Idle;
  assign done_o = done_q;
  assign rsp_o  = rsp_q;

endmodule

`default_nettype wire

@@ tb/sv/address_range_symbol_lookup_tb.sv @@
// Self-checking testbench for the sorted address range table with binary search lookup.
`timescale 1ns / 100ps

module address_range_symbol_lookup_tb;
  import arsl_pkg::*;

  localparam logic [1:0] ReqUnused = 2'd3;
  localparam int         RecentMax = 16;
  localparam int         WordGoal  = 1650;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;
  logic start  = 1'b0;
  req_t word_in = '0;
  logic busy;
  logic done;
  rsp_t word_out;

  req_t word_q[$];
  rsp_t pending_rsp_q[$];

  entry_t      tbl[TableDepth];
  int unsigned tbl_count = 0;
  int unsigned peak_count = 0;

  int accepted_count = 0;
  int fail_count = 0;
  int status_seen[8];

  int          gen_count = 0;
  logic [31:0] rec_start[$];
  logic [31:0] rec_len[$];

  address_range_symbol_lookup dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .req_i  (word_in),
    .done_o (done),
    .rsp_o  (word_out)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // Expected response of the table to one word; updates the table copy.
  function automatic rsp_t table_respond(input req_t w);
    rsp_t        r;
    int          pos;
    int          lo;
    int          hi;
    int          mid;
    logic [31:0] diff;
    r = '0;
    r.status = StMiss;
    case (w.req_type)
      ReqInsert: begin
        if (w.range_size == 0) begin
          r.status = StZero;
        end else if (tbl_count >= TableDepth) begin
          r.status = StFull;
        end else begin
          pos = 0;
          while (pos < int'(tbl_count) && tbl[pos].start <= w.address) pos++;
          for (int k = int'(tbl_count); k > pos; k--) tbl[k] = tbl[k - 1];
          tbl[pos].start       = w.address;
          tbl[pos].size        = w.range_size;
          tbl[pos].name_offset = w.name_offset;
          tbl[pos].section     = w.section_index;
          tbl[pos].object      = w.object_index;
          tbl_count++;
          if (tbl_count > peak_count) peak_count = tbl_count;
          r.status = StInserted;
        end
      end
      ReqLookup: begin
        lo = 0;
        hi = int'(tbl_count) - 1;
        while (hi >= lo) begin
          mid = (lo + hi) / 2;
          diff = w.address - tbl[mid].start;
          if (diff < tbl[mid].size) begin
            r.status            = StHit;
            r.found_name_offset = tbl[mid].name_offset;
            r.found_section     = tbl[mid].section;
            r.found_object      = tbl[mid].object;
            break;
          end
          if (tbl[mid].start < w.address) lo = mid + 1;
          else hi = mid - 1;
        end
      end
      ReqClear: begin
        tbl_count = 0;
        r.status = StCleared;
      end
      default: r.status = StMiss;
    endcase
    return r;
  endfunction

  function automatic logic [43:0] rand_tag();
    logic [63:0] v;
    v = {$urandom, $urandom};
    return v[43:0];
  endfunction

  task automatic push_word(input logic [1:0] kind, input logic [31:0] addr,
                           input logic [31:0] len, input logic [43:0] tag);
    req_t w;
    w.req_type   = kind;
    w.address    = addr;
    w.range_size = len;
    {w.name_offset, w.section_index, w.object_index} = tag;
    word_q.push_back(w);
    if (kind == ReqInsert && len != 0) begin
      gen_count++;
      rec_start.push_back(addr);
      rec_len.push_back(len);
      if (rec_start.size() > RecentMax) begin
        void'(rec_start.pop_front());
        void'(rec_len.pop_front());
      end
    end
  endtask

  task automatic push_clear();
    push_word(ReqClear, $urandom, $urandom, rand_tag());
    gen_count = 0;
    rec_start.delete();
    rec_len.delete();
  endtask

  function automatic logic [31:0] pick_size();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return $urandom_range(1, 256);
    if (r < 75) return $urandom_range(1, 65536);
    if (r < 85) return $urandom;
    if (r < 95) return 32'd0;
    return 32'd1;
  endfunction

  // Query address near a recently inserted range: inside, at its edges or just outside.
  function automatic logic [31:0] pick_probe();
    int          idx;
    logic [31:0] s;
    logic [31:0] l;
    if (rec_start.size() == 0) return $urandom;
    idx = $urandom_range(0, rec_start.size() - 1);
    s = rec_start[idx];
    l = rec_len[idx];
    case ($urandom_range(0, 4))
      0: return s;
      1: return s + $urandom_range(0, l - 1);
      2: return s + l - 1;
      3: return s + l;
      default: return s - 1;
    endcase
  endfunction

  task automatic small_episode();
    int          n;
    int          r;
    logic [31:0] a;
    push_clear();
    n = $urandom_range(1, 40);
    a = $urandom;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < 45) begin
        case ($urandom_range(0, 4))
          0: a = a;
          1: a = a - $urandom_range(1, 4096);
          default: a = a + $urandom_range(1, 512);
        endcase
        push_word(ReqInsert, a, pick_size(), rand_tag());
      end else if (r < 85) begin
        push_word(ReqLookup, pick_probe(), $urandom, rand_tag());
      end else if (r < 92) begin
        push_word(ReqLookup, $urandom, $urandom, rand_tag());
      end else if (r < 96) begin
        push_word(ReqUnused, $urandom, $urandom, rand_tag());
      end else begin
        push_word(ReqInsert, $urandom, pick_size(), rand_tag());
      end
    end
  endtask

  // Fills the table to the top, mostly in ascending order so that few entries move.
  task automatic fill_episode();
    logic [31:0] a;
    int          r;
    int          back_count;
    push_clear();
    a = $urandom_range(0, 32'h7FFF_FFFF);
    back_count = 0;
    while (gen_count < TableDepth) begin
      r = $urandom_range(0, 99);
      if (r < 10) begin
        push_word(ReqLookup, pick_probe(), $urandom, rand_tag());
      end else if (r < 11 && back_count < 6) begin
        push_word(ReqInsert, $urandom_range(0, a), $urandom_range(1, 1024), rand_tag());
        back_count++;
      end else begin
        a = a + $urandom_range(0, 64);
        push_word(ReqInsert, a, pick_size(), rand_tag());
      end
    end
    for (int i = 0; i < 3; i++) push_word(ReqInsert, $urandom, $urandom_range(1, 100), rand_tag());
    push_word(ReqInsert, $urandom, 32'd0, rand_tag());
    for (int i = 0; i < 10; i++) push_word(ReqLookup, pick_probe(), $urandom, rand_tag());
    push_word(ReqLookup, 32'h0000_0000, $urandom, rand_tag());
    push_word(ReqLookup, 32'hFFFF_FFFF, $urandom, rand_tag());
    push_word(ReqUnused, $urandom, $urandom, rand_tag());
  endtask

  task automatic build_stimulus();
    // Empty table, unused code and the wrapping range at the top of the address space.
    push_word(ReqLookup, 32'h0000_0000, 32'h0, rand_tag());
    push_word(ReqLookup, 32'hFFFF_FFFF, 32'hFFFF_FFFF, rand_tag());
    push_clear();
    push_word(ReqUnused, $urandom, $urandom, rand_tag());
    push_word(ReqInsert, 32'h0000_1000, 32'h0, '1);
    push_word(ReqInsert, 32'hFFFF_FFF0, 32'h20, '1);
    push_word(ReqLookup, 32'h0000_0005, 32'h0, '0);
    push_word(ReqLookup, 32'hFFFF_FFF0, 32'h0, '0);
    push_word(ReqLookup, 32'h0000_0010, 32'h0, '0);
    push_word(ReqInsert, 32'h0000_0000, 32'hFFFF_FFFF, '0);
    push_word(ReqInsert, 32'h0000_0000, 32'h1, {24'h80_0000, 8'h80, 12'h800});
    push_word(ReqLookup, 32'h0000_0000, 32'h0, '1);
    push_word(ReqLookup, 32'h8000_0000, 32'h0, '1);
    push_word(ReqLookup, 32'hFFFF_FFFE, 32'h0, '1);
    push_word(ReqInsert, 32'h0000_1000, 32'h10, rand_tag());
    push_word(ReqLookup, 32'h0000_100F, 32'h0, rand_tag());
    push_word(ReqLookup, 32'h0000_1010, 32'h0, rand_tag());
    push_word(ReqUnused, 32'hFFFF_FFFF, 32'hFFFF_FFFF, '1);
    push_word(ReqInsert, 32'h8000_0000, 32'h1, rand_tag());
    push_clear();
    push_word(ReqLookup, 32'h0000_1000, 32'h0, rand_tag());

    for (int i = 0; i < 8; i++) small_episode();
    fill_episode();
    while (word_q.size() < WordGoal) small_episode();
  endtask

  // Sender: holds a word on the inputs until the block takes it, idling by phase.
  always @(posedge clk_i) begin : drive
    logic nxt_start;
    req_t nxt_word;
    int   idle_pct;
    if (rst_ni) begin
      nxt_start = start;
      nxt_word  = word_in;
      case ((accepted_count / 150) % 3)
        0: idle_pct = 0;
        1: idle_pct = 56;
        default: idle_pct = 6;
      endcase
      if (start && !busy) begin
        pending_rsp_q.push_back(table_respond(word_in));
        accepted_count++;
        nxt_start = 1'b0;
      end
      if (!nxt_start && word_q.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
        nxt_word  = word_q.pop_front();
        nxt_start = 1'b1;
      end
      start   <= nxt_start;
      word_in <= nxt_word;
    end
  end

  always @(posedge clk_i) begin : watch
    rsp_t want;
    if (rst_ni && done) begin
      if (pending_rsp_q.size() == 0) begin
        $error("Result word with no request outstanding: status %0d", word_out.status);
        fail_count++;
      end else begin
        want = pending_rsp_q.pop_front();
        status_seen[want.status]++;
        if (word_out.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, word_out.status);
          fail_count++;
        end
        if (word_out.found_name_offset !== want.found_name_offset) begin
          $error("found_name_offset: expected 0x%06h, got 0x%06h",
                 want.found_name_offset, word_out.found_name_offset);
          fail_count++;
        end
        if (word_out.found_section !== want.found_section) begin
          $error("found_section: expected 0x%02h, got 0x%02h",
                 want.found_section, word_out.found_section);
          fail_count++;
        end
        if (word_out.found_object !== want.found_object) begin
          $error("found_object: expected 0x%03h, got 0x%03h",
                 want.found_object, word_out.found_object);
          fail_count++;
        end
      end
    end
  end

  initial begin
    #40_000_000;
    $display("Timed out with %0d result words outstanding.", pending_rsp_q.size());
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    build_stimulus();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    while (word_q.size() != 0 || start) @(posedge clk_i);
    while (pending_rsp_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    $display("Ran %0d request words; the table peaked at %0d of %0d entries.",
             accepted_count, peak_count, TableDepth);
    $display("Inserted %0d, zero size %0d, full %0d, hits %0d, misses %0d, clears %0d.",
             status_seen[StInserted], status_seen[StZero], status_seen[StFull],
             status_seen[StHit], status_seen[StMiss], status_seen[StCleared]);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
